/* src/sjis_escape_decoder_macros.svh */
// assertion macros shared by the shift-jis escape decoder rtl
`ifndef SJIS_ESCAPE_DECODER_MACROS_SVH
`define SJIS_ESCAPE_DECODER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SJISD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sjisd same-cycle check failed");

// next-cycle implication, checked out of reset
`define SJISD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sjisd next-cycle check failed");

`endif

/* src/sjisd_pkg.sv */
// shared types and constants for the shift-jis escape decoder
package sjisd_pkg;

    // pending mode carried from one byte to the next
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_TRAIL = 3'd1,
        MODE_ESC   = 3'd2,
        MODE_SLASH = 3'd3,
        MODE_DROP  = 3'd4
    } t_mode;

    // one result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_end;
        logic       bad_escape;
        logic       run_last;
    } t_result;

    // decoder output for one input byte
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
        t_mode      next_mode;
    } t_dec;

    // special byte values
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_SLASH     = 8'h2f;

    // lead byte ranges
    localparam logic [7:0] LEAD_A_LO = 8'h80;
    localparam logic [7:0] LEAD_A_HI = 8'ha0;
    localparam logic [7:0] LEAD_B_LO = 8'he0;
    localparam logic [7:0] LEAD_B_HI = 8'hfd;

    // result queue sizing
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 2;

endpackage

/* src/sjisd_decode.sv */
// per-byte decode: results and next pending mode for one byte
module sjisd_decode (
    input  sjisd_pkg::t_mode i_mode,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output sjisd_pkg::t_dec  o_dec
);

    logic             w_is_lead;
    logic             w_esc_known;
    logic [7:0]       w_esc_code;
    logic             w_f_emit;
    sjisd_pkg::t_result w_f_res;
    sjisd_pkg::t_mode w_f_mode;
    sjisd_pkg::t_result w_marker;
    sjisd_pkg::t_dec  w_dec;

    // lead byte classification
    assign w_is_lead = (i_byte > sjisd_pkg::LEAD_A_LO && i_byte < sjisd_pkg::LEAD_A_HI) ||
                       (i_byte >= sjisd_pkg::LEAD_B_LO && i_byte < sjisd_pkg::LEAD_B_HI);

    // escape letter lookup
    always_comb begin
        w_esc_known = 1'b1;
        w_esc_code  = 8'h00;
        case (i_byte)
            "n": w_esc_code = 8'h0a;
            "e": w_esc_code = 8'h01;
            "l": w_esc_code = 8'h02;
            "f": w_esc_code = 8'h02;
            "p": w_esc_code = 8'h03;
            "r": w_esc_code = 8'h05;
            "c": w_esc_code = 8'h12;
            "d": w_esc_code = 8'h13;
            "m": w_esc_code = 8'h1e;
            default: w_esc_known = 1'b0;
        endcase
    end

    // byte handled with nothing pending
    always_comb begin
        w_f_emit = 1'b1;
        w_f_mode = sjisd_pkg::MODE_IDLE;
        w_f_res  = '{out_byte: i_byte, byte_valid: 1'b1, string_end: i_last,
                     bad_escape: 1'b0, run_last: 1'b0};
        if (!i_last) begin
            if (w_is_lead) begin
                w_f_mode = sjisd_pkg::MODE_TRAIL;
            end else if (i_byte == sjisd_pkg::CHAR_BACKSLASH) begin
                w_f_emit = 1'b0;
                w_f_mode = sjisd_pkg::MODE_ESC;
            end else if (i_byte == sjisd_pkg::CHAR_SLASH) begin
                w_f_emit = 1'b0;
                w_f_mode = sjisd_pkg::MODE_SLASH;
            end
        end
    end

    // end of string marker with no byte
    assign w_marker = '{out_byte: 8'h00, byte_valid: 1'b0, string_end: 1'b1,
                        bad_escape: 1'b0, run_last: 1'b0};

    // mode dispatch
    always_comb begin
        w_dec.count     = 2'd0;
        w_dec.res0      = w_f_res;
        w_dec.res1      = w_f_res;
        w_dec.next_mode = sjisd_pkg::MODE_IDLE;
        case (i_mode)
            sjisd_pkg::MODE_TRAIL: begin
                w_dec.count = 2'd1;
                w_dec.res0  = '{out_byte: i_byte, byte_valid: 1'b1, string_end: i_last,
                                bad_escape: 1'b0, run_last: 1'b0};
            end
            sjisd_pkg::MODE_ESC: begin
                if (w_esc_known) begin
                    w_dec.count = 2'd1;
                    w_dec.res0  = '{out_byte: w_esc_code, byte_valid: 1'b1,
                                    string_end: i_last, bad_escape: 1'b0, run_last: 1'b0};
                end else begin
                    w_dec.count     = {w_f_emit, ~w_f_emit};
                    w_dec.res0      = '{out_byte: sjisd_pkg::CHAR_BACKSLASH, byte_valid: 1'b1,
                                        string_end: 1'b0, bad_escape: 1'b1, run_last: 1'b0};
                    w_dec.next_mode = w_f_mode;
                end
            end
            sjisd_pkg::MODE_SLASH: begin
                if (i_byte == sjisd_pkg::CHAR_SLASH) begin
                    if (i_last) begin
                        w_dec.count = 2'd1;
                        w_dec.res0  = w_marker;
                    end else begin
                        w_dec.next_mode = sjisd_pkg::MODE_DROP;
                    end
                end else begin
                    w_dec.count     = {w_f_emit, ~w_f_emit};
                    w_dec.res0      = '{out_byte: sjisd_pkg::CHAR_SLASH, byte_valid: 1'b1,
                                        string_end: 1'b0, bad_escape: 1'b0, run_last: 1'b0};
                    w_dec.next_mode = w_f_mode;
                end
            end
            sjisd_pkg::MODE_DROP: begin
                if (i_last) begin
                    w_dec.count = 2'd1;
                    w_dec.res0  = w_marker;
                end else begin
                    w_dec.next_mode = sjisd_pkg::MODE_DROP;
                end
            end
            default: begin
                w_dec.count     = {1'b0, w_f_emit};
                w_dec.next_mode = w_f_mode;
            end
        endcase
        // flag the last result of this byte
        if (w_dec.count == 2'd2) begin
            w_dec.res1.run_last = 1'b1;
        end else if (w_dec.count == 2'd1) begin
            w_dec.res0.run_last = 1'b1;
        end
    end

    assign o_dec = w_dec;

endmodule

/* src/sjisd_outq.sv */
// small result queue: takes up to two results a cycle, gives one beat a cycle while popped
module sjisd_outq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [1:0]                    i_push_cnt,
    input  sjisd_pkg::t_result            i_res0,
    input  sjisd_pkg::t_result            i_res1,
    input  logic                          i_pop,
    output sjisd_pkg::t_result            o_head,
    output logic                          o_not_empty,
    output logic                          o_room2,
    output logic [sjisd_pkg::QCNT_W-1:0]  o_count
);

    sjisd_pkg::t_result                r_buf [sjisd_pkg::QDEPTH];
    logic [sjisd_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [sjisd_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [sjisd_pkg::QCNT_W-1:0]      r_count;
    logic [sjisd_pkg::QPTR_W-1:0]      n_wr_ptr;
    logic [sjisd_pkg::QPTR_W-1:0]      n_rd_ptr;
    logic [sjisd_pkg::QCNT_W-1:0]      n_count;
    logic [sjisd_pkg::QPTR_W-1:0]      w_wr_ptr1;

    assign w_wr_ptr1 = r_wr_ptr + sjisd_pkg::QPTR_W'(1);

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr + sjisd_pkg::QPTR_W'(i_push_cnt);
        n_rd_ptr = r_rd_ptr + sjisd_pkg::QPTR_W'(i_pop);
        n_count  = r_count + sjisd_pkg::QCNT_W'(i_push_cnt) - sjisd_pkg::QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_buf[r_wr_ptr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_buf[w_wr_ptr1] <= i_res1;
        end
    end

    assign o_head      = r_buf[r_rd_ptr];
    assign o_not_empty = (r_count != '0);
    assign o_room2     = (r_count <= sjisd_pkg::QCNT_W'(sjisd_pkg::QDEPTH - 2));
    assign o_count     = r_count;

endmodule

/* src/sjis_escape_decoder.sv */
// top level: shift-jis escape decoder, one source byte per beat in, one result per beat out
// a byte waits in the input stage register until the queue has room; its results then go into the queue
// throughput: one byte per cycle while each byte gives at most one result and results are taken;
//   a byte giving two results takes two output beats
// the four-entry result queue sets the input stall: input stops when fewer than two slots free
// reset clears the pending mode to idle and empties the input stage and result queue
module sjis_escape_decoder (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input stream
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [sjisd_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,  // [7:0] data_byte
    input  logic                                 i_s_axis_tlast,  // string_last
    // result stream
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [sjisd_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,  // [7:0] out_byte, [8] run_last
    output logic [sjisd_pkg::OUT_TUSER_W-1:0]    o_m_axis_tuser,  // [0] byte_valid, [1] bad_escape
    output logic                                 o_m_axis_tlast   // string_end
);

    logic                              r_in_valid;
    logic [7:0]                        r_in_byte;
    logic                              r_in_last;
    sjisd_pkg::t_mode                  r_mode;
    sjisd_pkg::t_dec                   w_dec;
    sjisd_pkg::t_result                w_head;
    logic                              w_not_empty;
    logic                              w_room2;
    logic [sjisd_pkg::QCNT_W-1:0]      w_q_count;
    logic                              w_fire;
    logic                              w_in_beat;
    logic                              w_out_beat;
    logic [1:0]                        w_push_cnt;

    // handshake
    assign w_fire          = r_in_valid && w_room2;
    assign o_s_axis_tready = !r_in_valid || w_fire;
    assign w_in_beat       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_beat      = o_m_axis_tvalid && i_m_axis_tready;
    assign w_push_cnt      = w_fire ? w_dec.count : 2'd0;

    // input stage control and pending mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= sjisd_pkg::MODE_IDLE;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_fire) begin
                r_mode <= w_dec.next_mode;
            end
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_in_byte <= i_s_axis_tdata[7:0];
            r_in_last <= i_s_axis_tlast;
        end
    end

    sjisd_decode u_decode (
        .i_mode (r_mode),
        .i_byte (r_in_byte),
        .i_last (r_in_last),
        .o_dec  (w_dec)
    );

    sjisd_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (w_push_cnt),
        .i_res0      (w_dec.res0),
        .i_res1      (w_dec.res1),
        .i_pop       (w_out_beat),
        .o_head      (w_head),
        .o_not_empty (w_not_empty),
        .o_room2     (w_room2),
        .o_count     (w_q_count)
    );

    // result beat packing
    assign o_m_axis_tvalid = w_not_empty;
    assign o_m_axis_tdata  = {7'd0, w_head.run_last, w_head.out_byte};
    assign o_m_axis_tuser  = {w_head.bad_escape, w_head.byte_valid};
    assign o_m_axis_tlast  = w_head.string_end;

`include "sjis_escape_decoder_macros.svh"

    `SJISD_ASSERT_IMPL(a_q_no_overflow, 1'b1, w_q_count <= sjisd_pkg::QCNT_W'(sjisd_pkg::QDEPTH))
    `SJISD_ASSERT_NEXT(a_last_clears_mode, w_fire && r_in_last, r_mode == sjisd_pkg::MODE_IDLE)
    `SJISD_ASSERT_IMPL(a_pair_run_last, w_fire && w_dec.count == 2'd2,
                       w_dec.res1.run_last && !w_dec.res0.run_last && !w_dec.res0.string_end)
    `SJISD_ASSERT_IMPL(a_drop_silent, w_fire && r_mode == sjisd_pkg::MODE_DROP && !r_in_last,
                       w_dec.count == 2'd0)

endmodule
